// ===== src/ffha_pkg.sv =====
package ffha_pkg;

	localparam int MAX_BLOCKS   = 32;
	localparam int IDX_W        = $clog2(MAX_BLOCKS);
	localparam int HEADER_BYTES = 8;
	localparam int ALIGN_BYTES  = 4;
	localparam int START_W      = 16;
	localparam int LEN_W        = 17;
	localparam int ADDR_W       = 32;
	localparam int CFG_IDX_W    = 1;
	localparam int CFG_DATA_W   = 32;
	localparam int HEAP_MAX     = 65536;

	localparam logic [IDX_W-1:0]     HEAD_IDX   = IDX_W'(0);
	localparam logic [IDX_W-1:0]     TAIL_IDX   = IDX_W'(1);
	localparam logic [IDX_W-1:0]     LAST_STEP  = IDX_W'(MAX_BLOCKS - 1);
	localparam logic [START_W-1:0]   RESET_TAIL = START_W'(HEAP_MAX - HEADER_BYTES);
	localparam logic [CFG_IDX_W-1:0] REG_HEAP_BASE  = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_HEAP_BYTES = CFG_IDX_W'(1);
	localparam logic [LEN_W-1:0]     RESET_HEAP_BYTES = LEN_W'(HEAP_MAX);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOAD,
		ST_SCAN,
		ST_PLACE,
		ST_FREE,
		ST_DONE
	} seq_state_t;

	typedef struct packed {
		logic [START_W-1:0] start;
		logic [LEN_W-1:0]   length;
		logic [IDX_W-1:0]   link;
		logic               used;
	} entry_t;

	typedef struct packed {
		logic               init;
		logic [START_W-1:0] tail;
		logic               ent_we;
		logic [IDX_W-1:0]   ent_idx;
		entry_t             ent;
		logic               len_we;
		logic [IDX_W-1:0]   len_idx;
		logic [LEN_W-1:0]   len_val;
		logic               link_we;
		logic [IDX_W-1:0]   link_idx;
		logic [IDX_W-1:0]   link_val;
		logic               unuse_we;
		logic [IDX_W-1:0]   unuse_idx;
	} tbl_cmd_t;

	typedef struct packed {
		logic              valid;
		logic [ADDR_W-1:0] addr;
		logic              fail;
	} res_t;

endpackage

// ===== src/ffha_table.sv =====
module ffha_table
	import ffha_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  tbl_cmd_t              cmd,
	input  logic [IDX_W-1:0]      rd_idx,
	output entry_t                rd,
	output logic [MAX_BLOCKS-1:0] used_vec,
	output logic                  free_found,
	output logic [IDX_W-1:0]      free_idx
);

	logic [START_W-1:0] start_q  [MAX_BLOCKS];
	logic [LEN_W-1:0]   length_q [MAX_BLOCKS];
	logic [IDX_W-1:0]   link_q   [MAX_BLOCKS];
	logic               used_q   [MAX_BLOCKS];

	// hold the block table; init rebuilds the empty heap
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_BLOCKS; i++) begin
				start_q[i]  <= (IDX_W'(i) == TAIL_IDX) ? RESET_TAIL : '0;
				length_q[i] <= '0;
				link_q[i]   <= (IDX_W'(i) == HEAD_IDX || IDX_W'(i) == TAIL_IDX) ? TAIL_IDX : '0;
				used_q[i]   <= (IDX_W'(i) == HEAD_IDX || IDX_W'(i) == TAIL_IDX);
			end
		end else if (cmd.init) begin
			for (int i = 0; i < MAX_BLOCKS; i++) begin
				start_q[i]  <= (IDX_W'(i) == TAIL_IDX) ? cmd.tail : '0;
				length_q[i] <= '0;
				link_q[i]   <= (IDX_W'(i) == HEAD_IDX || IDX_W'(i) == TAIL_IDX) ? TAIL_IDX : '0;
				used_q[i]   <= (IDX_W'(i) == HEAD_IDX || IDX_W'(i) == TAIL_IDX);
			end
		end else begin
			if (cmd.ent_we) begin
				start_q[cmd.ent_idx]  <= cmd.ent.start;
				length_q[cmd.ent_idx] <= cmd.ent.length;
				link_q[cmd.ent_idx]   <= cmd.ent.link;
				used_q[cmd.ent_idx]   <= cmd.ent.used;
			end
			if (cmd.len_we) begin
				length_q[cmd.len_idx] <= cmd.len_val;
			end
			if (cmd.link_we) begin
				link_q[cmd.link_idx] <= cmd.link_val;
			end
			if (cmd.unuse_we) begin
				used_q[cmd.unuse_idx] <= 1'b0;
			end
		end
	end

	// read one entry per cycle
	always_comb begin
		rd.start  = start_q[rd_idx];
		rd.length = length_q[rd_idx];
		rd.link   = link_q[rd_idx];
		rd.used   = used_q[rd_idx];
	end

	// find the lowest unused slot above head and tail
	always_comb begin
		free_found = 1'b0;
		free_idx   = '0;
		for (int i = 0; i < MAX_BLOCKS; i++) begin
			used_vec[i] = used_q[i];
		end
		for (int i = MAX_BLOCKS - 1; i >= 2; i--) begin
			if (!used_q[i]) begin
				free_found = 1'b1;
				free_idx   = IDX_W'(i);
			end
		end
	end

endmodule

// ===== src/ffha_seq.sv =====
module ffha_seq
	import ffha_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic                action,
	input  logic [15:0]         request_bytes,
	input  logic [ADDR_W-1:0]   release_address,
	input  logic [ADDR_W-1:0]   heap_base,
	input  logic                out_free,
	output res_t                res,
	output logic [IDX_W-1:0]    rd_idx,
	input  entry_t              rd,
	input  logic                free_found,
	input  logic [IDX_W-1:0]    free_idx,
	output tbl_cmd_t            cmd
);

	seq_state_t state_q, state_d;

	logic [IDX_W-1:0]   cur_q, cur_d, prev_q, prev_d, clink_q, clink_d, steps_q, steps_d;
	logic [START_W-1:0] cs_q, cs_d;
	logic [LEN_W-1:0]   cl_q, cl_d, need_q, need_d;
	logic [ADDR_W-1:0]  off_q, off_d, addr_q, addr_d;
	logic               fail_q, fail_d;

	logic               accept;
	logic [LEN_W-1:0]   need_sum;
	logic [START_W+1:0] blk_end;
	logic               fits;
	logic               head_fill;
	logic               hit;
	logic [START_W-1:0] new_start;

	assign accept    = in_valid && in_ready;
	assign need_sum  = {1'b0, request_bytes} + LEN_W'(HEADER_BYTES + ALIGN_BYTES - 1);
	// shared add and compare: gap after current block against the need
	assign blk_end   = {2'b00, cs_q} + {1'b0, cl_q};
	assign fits      = ({3'b000, rd.start}) >= ({1'b0, blk_end} + {2'b00, need_q});
	assign head_fill = (cur_q == HEAD_IDX) && (cl_q == '0);
	assign new_start = blk_end[START_W-1:0];
	assign hit       = ({{(ADDR_W-START_W){1'b0}}, rd.start} == off_q);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (action) begin
						state_d = (release_address == '0) ? ST_DONE : ST_FREE;
					end else begin
						state_d = (request_bytes == '0) ? ST_DONE : ST_LOAD;
					end
				end
			end
			ST_LOAD: state_d = ST_SCAN;
			ST_SCAN: begin
				if (fits) begin
					state_d = ST_PLACE;
				end else if (clink_q == TAIL_IDX || steps_q == LAST_STEP) begin
					state_d = ST_DONE;
				end
			end
			ST_PLACE: state_d = ST_DONE;
			ST_FREE: begin
				if (hit || cur_q == TAIL_IDX || steps_q == LAST_STEP) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// datapath and table commands
	always_comb begin
		cur_d   = cur_q;
		prev_d  = prev_q;
		clink_d = clink_q;
		steps_d = steps_q;
		cs_d    = cs_q;
		cl_d    = cl_q;
		need_d  = need_q;
		off_d   = off_q;
		addr_d  = addr_q;
		fail_d  = fail_q;
		cmd     = '0;
		rd_idx  = cur_q;
		in_ready = (state_q == ST_IDLE);
		res.valid = (state_q == ST_DONE) && out_free;
		res.addr  = addr_q;
		res.fail  = fail_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					cur_d   = HEAD_IDX;
					prev_d  = HEAD_IDX;
					steps_d = '0;
					addr_d  = '0;
					fail_d  = 1'b1;
					need_d  = LEN_W'((need_sum / ALIGN_BYTES) * ALIGN_BYTES);
					off_d   = release_address - ADDR_W'(HEADER_BYTES) - heap_base;
				end
			end
			ST_LOAD: begin
				cs_d    = rd.start;
				cl_d    = rd.length;
				clink_d = rd.link;
			end
			ST_SCAN: begin
				rd_idx = clink_q;
				if (!fits) begin
					// advance to the next block
					cur_d   = clink_q;
					cs_d    = rd.start;
					cl_d    = rd.length;
					clink_d = rd.link;
					steps_d = steps_q + 1'b1;
				end
			end
			ST_PLACE: begin
				if (head_fill) begin
					cmd.len_we  = 1'b1;
					cmd.len_idx = HEAD_IDX;
					cmd.len_val = need_q;
					fail_d = 1'b0;
					addr_d = heap_base + ADDR_W'(cs_q) + ADDR_W'(HEADER_BYTES);
				end else if (free_found) begin
					// link a new block in after the current one
					cmd.ent_we     = 1'b1;
					cmd.ent_idx    = free_idx;
					cmd.ent.start  = new_start;
					cmd.ent.length = need_q;
					cmd.ent.link   = clink_q;
					cmd.ent.used   = 1'b1;
					cmd.link_we    = 1'b1;
					cmd.link_idx   = cur_q;
					cmd.link_val   = free_idx;
					fail_d = 1'b0;
					addr_d = heap_base + ADDR_W'(new_start) + ADDR_W'(HEADER_BYTES);
				end
			end
			ST_FREE: begin
				if (hit) begin
					if (cur_q == HEAD_IDX) begin
						cmd.len_we  = 1'b1;
						cmd.len_idx = HEAD_IDX;
						cmd.len_val = '0;
						fail_d = 1'b0;
					end else if (cur_q != TAIL_IDX) begin
						// unlink the block
						cmd.link_we   = 1'b1;
						cmd.link_idx  = prev_q;
						cmd.link_val  = rd.link;
						cmd.len_we    = 1'b1;
						cmd.len_idx   = cur_q;
						cmd.len_val   = '0;
						cmd.unuse_we  = 1'b1;
						cmd.unuse_idx = cur_q;
						fail_d = 1'b0;
					end
				end else begin
					prev_d  = cur_q;
					cur_d   = rd.link;
					steps_d = steps_q + 1'b1;
				end
			end
			ST_DONE: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		cur_q   <= cur_d;
		prev_q  <= prev_d;
		clink_q <= clink_d;
		steps_q <= steps_d;
		cs_q    <= cs_d;
		cl_q    <= cl_d;
		need_q  <= need_d;
		off_q   <= off_d;
		addr_q  <= addr_d;
		fail_q  <= fail_d;
	end

endmodule

// ===== src/first_fit_heap_allocator_core.sv =====
// First-fit heap allocator over an address-ordered table of blocks.
// Input channel (in_valid/in_ready): action 0 allocates request_bytes of
// payload, action 1 frees release_address. Each beat yields exactly one beat
// on the output channel (out_valid/out_ready): granted_address and failed.
// One item is in work at a time; in_ready is high only while idle.
// An allocate loads the head entry, walks the blocks in address order (1..32
// of them) until a gap fits, then places the block; an allocate that finds
// no gap ends after the walk; a free walks the blocks until one matches; a
// zero request or a null free goes straight to the result. The table walk
// sets the worst case; it reads one entry per cycle through one read port
// and one shared add/compare.
// The result sits in an output register; while the receiver stalls the
// sequencer holds its finished result and takes no new item.
// Reset (arst_n low) empties the heap: head block at offset 0 with length 0,
// tail sentinel one header below the heap end. A configuration write
// (cfg_we) rebuilds the table the same way and is meant for idle periods.
module first_fit_heap_allocator_core
	import ffha_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic                  action,
	input  logic [15:0]           request_bytes,
	input  logic [ADDR_W-1:0]     release_address,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [ADDR_W-1:0]     granted_address,
	output logic                  failed,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	logic [ADDR_W-1:0] heap_base_q;
	logic [LEN_W-1:0]  heap_bytes_q, bytes_d, size_d;
	logic [START_W-1:0] tail_d;

	logic              out_valid_q;
	logic [ADDR_W-1:0] granted_q;
	logic              failed_q;
	logic              out_free;

	res_t                  res;
	tbl_cmd_t              seq_cmd, tbl_cmd;
	entry_t                rd;
	logic [IDX_W-1:0]      rd_idx, free_idx;
	logic [MAX_BLOCKS-1:0] used_vec;
	logic                  free_found;

	// hold configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			heap_base_q  <= '0;
			heap_bytes_q <= RESET_HEAP_BYTES;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_HEAP_BASE:  heap_base_q  <= cfg_data[ADDR_W-1:0];
				REG_HEAP_BYTES: heap_bytes_q <= cfg_data[LEN_W-1:0];
				default: ;
			endcase
		end
	end

	// place tail sentinel from the heap size being written
	always_comb begin
		bytes_d = (cfg_index == REG_HEAP_BYTES) ? cfg_data[LEN_W-1:0] : heap_bytes_q;
		size_d  = (bytes_d > LEN_W'(HEAP_MAX)) ? LEN_W'(HEAP_MAX) : bytes_d;
		tail_d  = (size_d >= LEN_W'(HEADER_BYTES)) ?
			START_W'(size_d - LEN_W'(HEADER_BYTES)) : '0;
		tbl_cmd      = seq_cmd;
		tbl_cmd.init = cfg_we;
		tbl_cmd.tail = tail_d;
	end

	ffha_seq u_seq (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.action          (action),
		.request_bytes   (request_bytes),
		.release_address (release_address),
		.heap_base       (heap_base_q),
		.out_free        (out_free),
		.res             (res),
		.rd_idx          (rd_idx),
		.rd              (rd),
		.free_found      (free_found),
		.free_idx        (free_idx),
		.cmd             (seq_cmd)
	);

	ffha_table u_table (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (tbl_cmd),
		.rd_idx     (rd_idx),
		.rd         (rd),
		.used_vec   (used_vec),
		.free_found (free_found),
		.free_idx   (free_idx)
	);

	// output register: load a finished result, drop it on the taken beat
	assign out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res.valid) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res.valid) begin
			granted_q <= res.fail ? '0 : res.addr;
			failed_q  <= res.fail;
		end
	end

	assign out_valid       = out_valid_q;
	assign granted_address = granted_q;
	assign failed          = failed_q;

	// busy after taking a beat
	assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("accepted a beat while busy");

	// a failed result never carries an address
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && failed) |-> (granted_address == '0))
		else $error("failed result with address");

	// head and tail stay in the table
	assert property (@(posedge clk) disable iff (!arst_n)
		used_vec[HEAD_IDX] && used_vec[TAIL_IDX])
		else $error("head or tail slot released");

	// a result is loaded only into a free output register
	assert property (@(posedge clk) disable iff (!arst_n)
		res.valid |-> out_free)
		else $error("result overwrote pending beat");

endmodule
